### hdl/wlp_pkg.sv
// Shared constants, state type and rank helper for the windowed latency percentile tracker.
`timescale 1ns / 1ps

package wlp_pkg;

   localparam int WINDOW     = 64;
   localparam int IDX_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int LAT_W      = 32;
   localparam int SAMPLE_W   = 31;
   localparam int TOTAL_W    = 48;
   localparam int COUNT_W    = 7;
   localparam int RSP_BITS   = 3 * SAMPLE_W + TOTAL_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // action codes carried in tuser
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_LOAD     = 8'b0000_0010,
      ST_DELETE   = 8'b0000_0100,
      ST_INSERT   = 8'b0000_1000,
      ST_INS_HEAD = 8'b0001_0000,
      ST_LOOKUP   = 8'b0010_0000,
      ST_DONE     = 8'b0100_0000,
      ST_SPARE    = 8'b1000_0000
   } state_type;

   // rank of the 95th percentile: n*95/100, less one from 20 samples up.
   // n*95 by shift-add, /100 by reciprocal 5243/2^19 (exact for n <= 64).
   function automatic logic [IDX_W-1:0] high_rank(input logic [CNT_W-1:0] n);
      logic [12:0] x;
      logic [25:0] prod;
      logic [6:0]  q;
      x    = (13'(n) << 7) - (13'(n) << 5) - 13'(n);
      prod = 26'(x) * 26'd5243;
      q    = prod[25:19];
      if (n >= CNT_W'(20)) begin
         q = q - 7'd1;
      end
      return q[IDX_W-1:0];
   endfunction

endpackage

### hdl/windowed_latency_percentiles.sv
// Windowed latency percentile tracker: ring and sorted window in memory, insertion walk.
// Sample: with the window full, an ascending delete walk removes the evicted entry first;
//   a descending insert walk then places the sample, one entry a cycle (no walk when empty).
// Clear skips the walks. One transaction in flight; the next is taken only after the result
//   enters the rsp register, which waits while the sink still holds an earlier result.
// Reset (synchronous): empties window, counts, total, peak; memories unswept, fill bounds reads.
`timescale 1ns / 1ps

module windowed_latency_percentiles
   import wlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [LAT_W-1:0]      req_tdata,   // [31:0] latency_ms (signed)
   input  logic [0:0]            req_tuser,   // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // median_ms, high_pct_ms, peak_ms,
                                              // total_ms, valid_count, zero pad
);

   // control
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [SAMPLE_W-1:0]  peak_ff, peak_in;
   logic                 issue_ff, issue_in;    // walk read still being issued
   logic                 pv_ff, pv_in;          // read data of walk valid
   logic                 found_ff, found_in;    // evicted value located
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [SAMPLE_W-1:0]  old_ff, old_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic [SAMPLE_W-1:0]  ring_mem [WINDOW];
   logic [SAMPLE_W-1:0]  sorted_mem [WINDOW];
   logic [SAMPLE_W-1:0]  ring_q, rd_a_q, rd_b_q;

   logic                 ring_we;
   logic                 sort_we;
   logic [IDX_W-1:0]     sort_wa;
   logic [SAMPLE_W-1:0]  sort_wd;
   logic [IDX_W-1:0]     addr_a, addr_b;

   logic                 req_take;
   logic [SAMPLE_W-1:0]  clamped;
   logic [TOTAL_W:0]     sum_wide;
   logic [CNT_W-1:0]     fill_less;
   logic [IDX_W-1:0]     mid_rank;
   logic [IDX_W-1:0]     top_rank;
   logic [SAMPLE_W-1:0]  med_val, high_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // negative latency taken as zero
   assign clamped  = req_tdata[LAT_W-1] ? '0 : req_tdata[SAMPLE_W-1:0];
   assign sum_wide = {1'b0, total_ff} + (TOTAL_W + 1)'(clamped);

   assign fill_less = fill_ff - CNT_W'(1);
   assign mid_rank  = fill_less[IDX_W:1];
   assign top_rank  = high_rank(fill_ff);

   assign med_val  = (fill_ff == '0) ? '0 : rd_a_q;
   assign high_val = (fill_ff == '0) ? '0 : rd_b_q;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      peak_in      = peak_ff;
      issue_in     = issue_ff;
      pv_in        = 1'b0;
      found_in     = found_ff;
      sample_in    = sample_ff;
      old_in       = old_ff;
      rd_idx_in    = rd_idx_ff;
      pidx_in      = rd_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ring_we      = 1'b0;
      sort_we      = 1'b0;
      sort_wa      = '0;
      sort_wd      = sample_ff;
      addr_a       = mid_rank;
      addr_b       = top_rank;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser[0] == ACT_CLEAR) begin
                  slot_in  = '0;
                  fill_in  = '0;
                  total_in = '0;
                  peak_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  sample_in = clamped;
                  total_in  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
                  if (clamped > peak_ff) begin
                     peak_in = clamped;
                  end
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            // ring_q holds the entry about to be overwritten
            old_in   = ring_q;
            ring_we  = 1'b1;
            slot_in  = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + IDX_W'(1);
            found_in = 1'b0;
            if (fill_ff == CNT_W'(WINDOW)) begin
               rd_idx_in = '0;
               issue_in  = 1'b1;
               state_in  = ST_DELETE;
            end else begin
               fill_in = fill_ff + CNT_W'(1);
               if (fill_ff == '0) begin
                  sort_we  = 1'b1;
                  sort_wa  = '0;
                  state_in = ST_LOOKUP;
               end else begin
                  rd_idx_in = fill_less[IDX_W-1:0];
                  issue_in  = 1'b1;
                  state_in  = ST_INSERT;
               end
            end
         end

         ST_DELETE: begin
            // ascending walk: drop first copy of the evicted value, close the gap
            addr_a = rd_idx_ff;
            pv_in  = issue_ff;
            if (issue_ff) begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
               if (rd_idx_ff == IDX_W'(WINDOW - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (pv_ff) begin
               if (found_ff) begin
                  sort_we = 1'b1;
                  sort_wa = pidx_ff - IDX_W'(1);
                  sort_wd = rd_a_q;
               end else if (rd_a_q == old_ff) begin
                  found_in = 1'b1;
               end
               if (pidx_ff == IDX_W'(WINDOW - 1)) begin
                  rd_idx_in = IDX_W'(WINDOW - 2);
                  issue_in  = 1'b1;
                  pv_in     = 1'b0;
                  state_in  = ST_INSERT;
               end
            end
         end

         ST_INSERT: begin
            // descending walk: shift larger entries up one, drop sample in the hole
            addr_a = rd_idx_ff;
            pv_in  = issue_ff;
            if (issue_ff) begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
               if (rd_idx_ff == '0) begin
                  issue_in = 1'b0;
               end
            end
            if (pv_ff) begin
               sort_we = 1'b1;
               sort_wa = pidx_ff + IDX_W'(1);
               if (rd_a_q > sample_ff) begin
                  sort_wd = rd_a_q;
                  if (pidx_ff == '0) begin
                     issue_in = 1'b0;
                     pv_in    = 1'b0;
                     state_in = ST_INS_HEAD;
                  end
               end else begin
                  sort_wd  = sample_ff;
                  issue_in = 1'b0;
                  pv_in    = 1'b0;
                  state_in = ST_LOOKUP;
               end
            end
         end

         ST_INS_HEAD: begin
            // sample is the new smallest
            sort_we  = 1'b1;
            sort_wa  = '0;
            state_in = ST_LOOKUP;
         end

         ST_LOOKUP: begin
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSP_DATA_W'({COUNT_W'(fill_ff), total_ff, peak_ff,
                                           high_val, med_val});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         issue_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         issue_ff     <= issue_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      old_ff      <= old_in;
      rd_idx_ff   <= rd_idx_in;
      pidx_ff     <= pidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ring of samples in arrival order
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      ring_q <= ring_mem[slot_ff];
   end

   // window in ascending order, two read ports
   always_ff @(posedge clock) begin
      if (sort_we) begin
         sorted_mem[sort_wa] <= sort_wd;
      end
      rd_a_q <= sorted_mem[addr_a];
      rd_b_q <= sorted_mem[addr_b];
   end

endmodule

### test/windowed_latency_percentiles_tb.sv
// Self-checking testbench for the windowed latency percentile tracker.
`timescale 1ns / 1ps

module windowed_latency_percentiles_tb;
   import wlp_pkg::*;

   // response field offsets inside rsp_tdata, lowest field first
   localparam int MED_LSB   = 0;
   localparam int HIGH_LSB  = MED_LSB + SAMPLE_W;
   localparam int PEAK_LSB  = HIGH_LSB + SAMPLE_W;
   localparam int TOTAL_LSB = PEAK_LSB + SAMPLE_W;
   localparam int COUNT_LSB = TOTAL_LSB + TOTAL_W;

   // the watchdog limit must exceed a full-window sample plus the longest sink stall
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 160;

   typedef struct {
      logic [SAMPLE_W-1:0] median;
      logic [SAMPLE_W-1:0] high_pct;
      logic [SAMPLE_W-1:0] peak;
      logic [TOTAL_W-1:0]  total;
      logic [COUNT_W-1:0]  count;
   } window_stats_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [LAT_W-1:0]      req_tdata  = '0;   // [31:0] latency_ms (signed)
   logic [0:0]            req_tuser  = ACT_SAMPLE;   // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // median, high_pct, peak, total, count, zero pad

   // shadow of the tracker state, updated on every accepted request
   logic [SAMPLE_W-1:0] shadow_ring [WINDOW];
   int                  shadow_slot;
   int                  shadow_fill;
   logic [TOTAL_W-1:0]  shadow_total;
   logic [SAMPLE_W-1:0] shadow_peak;

   window_stats_type pending_stats [$];   // expected responses, oldest first
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;

   // traffic shaping, written only by the test sequence
   bit tx_idling = 1'b0;
   bit rx_idling = 1'b0;
   int hold_asked = 0;

   // receiver-side stall bookkeeping, owned by the sink process
   int hold_served = 0;
   int stall_left  = 0;
   int sink_roll;

   always #1 clock = ~clock;

   windowed_latency_percentiles u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------- predictor

   function automatic void clear_shadow();
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
      shadow_slot  = 0;
      shadow_fill  = 0;
      shadow_total = '0;
      shadow_peak  = '0;
   endfunction

   // Applies one request to the shadow state and returns the statistics the
   // tracker must report afterwards.
   function automatic window_stats_type predict_stats(input logic act,
                                                      input logic [LAT_W-1:0] lat);
      window_stats_type    st;
      logic [SAMPLE_W-1:0] ranked [WINDOW];
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] v;
      int                  n;
      int                  j;
      int                  r50;
      int                  r95;

      if (act == ACT_CLEAR) begin
         clear_shadow();
      end else begin
         // negative latency counts as zero
         s = lat[LAT_W-1] ? '0 : lat[SAMPLE_W-1:0];
         if (shadow_total > TOTAL_MAX - TOTAL_W'(s)) begin
            shadow_total = TOTAL_MAX;
         end else begin
            shadow_total = shadow_total + TOTAL_W'(s);
         end
         if (s > shadow_peak) begin
            shadow_peak = s;
         end
         shadow_ring[shadow_slot] = s;
         shadow_slot = (shadow_slot + 1 >= WINDOW) ? 0 : shadow_slot + 1;
         if (shadow_fill < WINDOW) begin
            shadow_fill++;
         end
      end

      st.median   = '0;
      st.high_pct = '0;
      n = shadow_fill;
      if (n > 0) begin
         // ascending insertion sort of the occupied entries
         for (int i = 0; i < n; i++) begin
            v = shadow_ring[i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         r50 = (n - 1) / 2;
         r95 = (n * 95) / 100;
         if (n >= 20) begin
            r95--;
         end
         if (r95 >= n) begin
            r95 = n - 1;
         end
         st.median   = ranked[r50];
         st.high_pct = ranked[r95];
         if (st.high_pct < st.median) begin
            st.high_pct = ranked[n-1];
         end
      end
      st.peak  = shadow_peak;
      st.total = shadow_total;
      st.count = COUNT_W'(shadow_fill);
      return st;
   endfunction

   // ---------------------------------------------------------------- request side

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!tx_idling || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Offers one request and returns once it has been taken. tvalid is left
   // high so a back-to-back request need not toggle it; anything that
   // waits afterwards must drop it first.
   task automatic send_latency(input logic act, input logic [LAT_W-1:0] lat);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= lat;
      do @(posedge clock); while (!req_tready);
      pending_stats.push_back(predict_stats(act, lat));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   // mixes duplicates, full-range words (negatives included) and values near the top
   function automatic logic [LAT_W-1:0] random_latency();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         return LAT_W'($urandom_range(0, 40));
      end else if (roll < 55) begin
         return LAT_W'($urandom_range(0, 100000));
      end else if (roll < 80) begin
         return $urandom();
      end else if (roll < 90) begin
         return 32'h7FFF_FFFF - LAT_W'($urandom_range(0, 255));
      end
      return 32'h8000_0000 | $urandom();
   endfunction

   // ---------------------------------------------------------------- response side

   // sink: tready always high, or random when rx_idling; long hold-off on request from the test sequence
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         stall_left  = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (!rx_idling) begin
         rsp_tready <= 1'b1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_roll < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = (sink_roll < 95) ? $urandom_range(0, 3) : $urandom_range(15, 80);
         end
      end
   end

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      end
   endtask

   // scoreboard: every response transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h", $realtime,
                     rsp_tdata);
         end else begin
            check_field("median_ms", TOTAL_W'(pending_stats[0].median),
                        TOTAL_W'(rsp_tdata[MED_LSB +: SAMPLE_W]));
            check_field("high_pct_ms", TOTAL_W'(pending_stats[0].high_pct),
                        TOTAL_W'(rsp_tdata[HIGH_LSB +: SAMPLE_W]));
            check_field("peak_ms", TOTAL_W'(pending_stats[0].peak),
                        TOTAL_W'(rsp_tdata[PEAK_LSB +: SAMPLE_W]));
            check_field("total_ms", pending_stats[0].total,
                        rsp_tdata[TOTAL_LSB +: TOTAL_W]);
            check_field("valid_count", TOTAL_W'(pending_stats[0].count),
                        TOTAL_W'(rsp_tdata[COUNT_LSB +: COUNT_W]));
            void'(pending_stats.pop_front());
         end
      end
   end

   // watchdog: a stretch with no transaction on either side that outlasts WATCHDOG_LIMIT is a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // clear on an empty window; the latency word must be ignored
   task automatic test_empty_clear();
      send_latency(ACT_CLEAR, 32'hFFFF_FFFF);
      send_latency(ACT_CLEAR, $urandom());
      wait_for_drain();
   endtask

   // field extremes, negative clamping, duplicates and a clear with a live window
   task automatic test_sample_extremes();
      send_latency(ACT_SAMPLE, 32'h0000_0000);
      send_latency(ACT_SAMPLE, 32'h7FFF_FFFF);
      send_latency(ACT_SAMPLE, 32'h8000_0000);   // most negative, counts as zero
      send_latency(ACT_SAMPLE, 32'hFFFF_FFFF);   // -1, counts as zero
      send_latency(ACT_SAMPLE, 32'h0000_0001);
      send_latency(ACT_SAMPLE, 32'h7FFF_FFFE);
      send_latency(ACT_SAMPLE, 32'h5555_5555);
      send_latency(ACT_SAMPLE, 32'h2AAA_AAAA);
      send_latency(ACT_SAMPLE, 32'h2AAA_AAAA);
      send_latency(ACT_CLEAR,  32'h7FFF_FFFF);
      send_latency(ACT_SAMPLE, 32'h0000_0064);
      send_latency(ACT_SAMPLE, 32'h0000_0064);
      send_latency(ACT_SAMPLE, 32'h0000_0010);
      send_latency(ACT_CLEAR,  32'h0000_0000);
      wait_for_drain();
   endtask

   // mostly samples, so the window fills, passes the 20-sample rank step and
   // wraps, several times on a long run; a rare clear starts it over.
   // The total saturates only after ~2^17 maximal samples, too long to reach here.
   task automatic test_random_traffic(input int items, input bit idling);
      tx_idling = idling;
      rx_idling = idling;
      repeat (items) begin
         if ($urandom_range(0, 199) == 0) begin
            send_latency(ACT_CLEAR, $urandom());
         end else begin
            send_latency(ACT_SAMPLE, random_latency());
         end
      end
      wait_for_drain();
   endtask

   // sink holds off for a long stretch while requests keep coming back to back
   task automatic test_backpressure();
      tx_idling = 1'b0;
      hold_asked++;
      while (hold_served != hold_asked) @(posedge clock);
      repeat (12) send_latency(ACT_SAMPLE, random_latency());
      wait_for_drain();
   endtask

   initial begin
      clear_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_clear();
      test_sample_extremes();
      test_random_traffic(100, 1'b0);
      test_backpressure();
      test_random_traffic(500, 1'b1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
